### rtl/core/periodic_reminder_pulse_timer_core_assert.svh
// ----------------------------------------------------------------------------
// periodic reminder pulse timer assertion macros
// shared concurrent assertion forms used by the core modules
// ----------------------------------------------------------------------------
`ifndef PERIODIC_REMINDER_PULSE_TIMER_CORE_ASSERT_SVH
`define PERIODIC_REMINDER_PULSE_TIMER_CORE_ASSERT_SVH

// same-cycle implication, off while in reset
`define PRPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prpt assertion failed");

// next-cycle implication, off while in reset
`define PRPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prpt assertion failed");

`endif

### rtl/core/prpt_pkg.sv
// ----------------------------------------------------------------------------
// prpt_pkg
// types and constants shared by the periodic reminder pulse timer core
// ----------------------------------------------------------------------------
package prpt_pkg;

  localparam int PERIOD_W = 10;
  localparam int MS_W     = 20;
  localparam int TIME_W   = 32;
  localparam int STEPS_W  = 9;
  localparam int REM_W    = 10;

  localparam int DEF_PULSE_MS       = 800;
  localparam int DEF_MAX_PERIOD_SEC = 900;
  localparam int MIN_PERIOD_SEC     = 10;
  localparam int RESET_PERIOD_SEC   = 30;
  localparam int STEP_SEC           = 5;
  localparam int MS_PER_SEC         = 1000;
  localparam int ROUND_UP_MS        = 999;
  localparam int REMAIN_MAX         = 1023;
  localparam int SAT_MS             = REMAIN_MAX * MS_PER_SEC;

  // floor(x / 1000) = (x * RECIP) >> RECIP_SHIFT for x below 2^21
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 21;
  localparam int RECIP       = 1073742;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_SERVICE = 2'd0;
  localparam mode_t MODE_TOGGLE  = 2'd1;
  localparam mode_t MODE_STOP    = 2'd2;
  localparam mode_t MODE_ADJUST  = 2'd3;

  typedef logic [PERIOD_W-1:0] period_t;
  typedef logic [MS_W-1:0]     ms_t;
  typedef logic [TIME_W-1:0]   time_t;
  typedef logic [REM_W-1:0]    rem_t;

  typedef struct packed {
    mode_t                      mode;
    time_t                      now_ms;
    logic                       allow_outputs;
    logic signed [STEPS_W-1:0]  delta_steps;
  } item_t;

  // service outcome handed from the state update to the remaining-time stage
  typedef struct packed {
    logic    active;
    period_t per_secs;
    rem_t    rem_direct;
    logic    use_div;
    time_t   diff_ms;
    logic    pulse_act;
  } svc_t;

  typedef struct packed {
    logic    pulse_act;
    rem_t    rem_secs;
    period_t per_secs;
    logic    active;
  } result_t;

endpackage

### rtl/core/periodic_reminder_pulse_timer_core.sv
// ----------------------------------------------------------------------------
// periodic_reminder_pulse_timer_core
// path: input register, then service outcome register, then result output register
// throughput: one transaction per cycle, unless output back-pressure stalls a service item
// reset: synchronous active-low, period 30 s, disarmed, deadline and pulse 0
// configuration writes are taken every cycle and re-initialize the timer
// ----------------------------------------------------------------------------
module periodic_reminder_pulse_timer_core import prpt_pkg::*; #(
  parameter int PULSE_MS       = DEF_PULSE_MS,
  parameter int MAX_PERIOD_SEC = DEF_MAX_PERIOD_SEC
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,      // default period in seconds
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,      // now_ms, allow_outputs, delta_steps, zero pad
  input  logic [1:0]  in_tuser,      // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata      // active, period, remaining time,
                                     // pulse flag, zero pad
);

  logic    in_v_r;
  item_t   item_r;
  logic    item_ready;
  logic    svc_valid;
  svc_t    svc;
  logic    svc_ready;
  logic    res_valid;
  result_t res;

  assign cfg_ready = 1'b1;
  assign in_tready = !in_v_r || item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.mode          <= in_tuser;
      item_r.now_ms        <= in_tdata[31:0];
      item_r.allow_outputs <= in_tdata[32];
      item_r.delta_steps   <= in_tdata[41:33];
    end
  end

  prpt_ctrl #(
    .PULSE_MS       (PULSE_MS),
    .MAX_PERIOD_SEC (MAX_PERIOD_SEC)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .item_valid (in_v_r),
    .item       (item_r),
    .item_ready (item_ready),
    .svc_valid  (svc_valid),
    .svc        (svc),
    .svc_ready  (svc_ready)
  );

  prpt_remain u_remain (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (svc_valid),
    .s         (svc),
    .s_ready   (svc_ready),
    .out_valid (res_valid),
    .out_res   (res),
    .out_ready (out_tready)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {2'b00, res.pulse_act, res.rem_secs, res.per_secs,
                       res.active};

endmodule

### rtl/core/prpt_ctrl.sv
// ----------------------------------------------------------------------------
// prpt_ctrl
// timer state, per-item state update and service outcome register
// ----------------------------------------------------------------------------
module prpt_ctrl import prpt_pkg::*; #(
  parameter int PULSE_MS       = DEF_PULSE_MS,
  parameter int MAX_PERIOD_SEC = DEF_MAX_PERIOD_SEC
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_valid,
  input  period_t cfg_data,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_ready,
  output logic    svc_valid,
  output svc_t    svc,
  input  logic    svc_ready
);

  localparam period_t MIN_P  = PERIOD_W'(MIN_PERIOD_SEC);
  localparam period_t MAX_P  = PERIOD_W'(MAX_PERIOD_SEC);
  localparam ms_t     MIN_MS = MS_W'(MIN_PERIOD_SEC * MS_PER_SEC);
  localparam ms_t     MAX_MS = MS_W'(MAX_PERIOD_SEC * MS_PER_SEC);
  localparam ms_t     MS_K   = MS_W'(MS_PER_SEC);
  localparam int      RST_SEC = (RESET_PERIOD_SEC > MAX_PERIOD_SEC) ? MAX_PERIOD_SEC :
                                                                      RESET_PERIOD_SEC;
  localparam period_t RST_P  = PERIOD_W'(RST_SEC);
  localparam ms_t     RST_MS = MS_W'(RST_SEC * MS_PER_SEC);

  logic    armed_r, armed_nxt;
  period_t period_r, period_nxt;
  ms_t     pm_r, pm_nxt;
  time_t   deadline_r, deadline_nxt;
  time_t   pulse_end_r, pulse_end_nxt;
  logic    svc_v_r;
  svc_t    svc_r, svc_nxt;

  logic    stage_ready;
  logic    fire;

  logic [TIME_W:0]  dl_sum;
  logic [TIME_W:0]  pl_sum;
  logic             reached;
  period_t          cfg_p;
  ms_t              cfg_pm;
  logic signed [12:0] steps_ext;
  logic signed [12:0] steps5;
  logic [12:0]      np;
  period_t          adj_p;
  logic [22:0]      steps_ms;
  logic [22:0]      npm;
  ms_t              adj_pm;
  logic [TIME_W:0]  adj_dl;

  assign stage_ready = !svc_v_r || svc_ready;
  assign item_ready  = (item.mode != MODE_SERVICE) || stage_ready;
  assign fire        = item_valid && item_ready;

  // shared adds and compares
  assign dl_sum  = {1'b0, item.now_ms} + {{(TIME_W+1-MS_W){1'b0}}, pm_r};
  assign pl_sum  = {1'b0, item.now_ms} + (TIME_W+1)'(PULSE_MS);
  assign reached = item.now_ms >= deadline_r;

  // configuration init
  assign cfg_p  = (cfg_data < MIN_P) ? MIN_P : ((cfg_data > MAX_P) ? MAX_P : cfg_data);
  assign cfg_pm = MS_W'({{(MS_W-PERIOD_W){1'b0}}, cfg_p} * MS_K);

  // period adjust, seconds and milliseconds clamped side by side
  assign steps_ext = {{(13-STEPS_W){item.delta_steps[STEPS_W-1]}}, item.delta_steps};
  assign steps5    = (steps_ext <<< 2) + steps_ext;
  assign np        = {3'b000, period_r} + steps5;
  assign adj_p     = np[12] ? MIN_P :
                     (np[11:0] < {2'b00, MIN_P}) ? MIN_P :
                     (np[11:0] > {2'b00, MAX_P}) ? MAX_P : np[PERIOD_W-1:0];
  assign steps_ms  = {{10{steps5[12]}}, steps5} * 23'(MS_PER_SEC);
  assign npm       = {3'b000, pm_r} + steps_ms;
  assign adj_pm    = npm[22] ? MIN_MS :
                     (npm[21:0] < {2'b00, MIN_MS}) ? MIN_MS :
                     (npm[21:0] > {2'b00, MAX_MS}) ? MAX_MS : npm[MS_W-1:0];
  assign adj_dl    = {1'b0, item.now_ms} + {{(TIME_W+1-MS_W){1'b0}}, adj_pm};

  always_comb begin
    armed_nxt     = armed_r;
    period_nxt    = period_r;
    pm_nxt        = pm_r;
    deadline_nxt  = deadline_r;
    pulse_end_nxt = pulse_end_r;
    if (cfg_valid) begin
      armed_nxt     = 1'b0;
      period_nxt    = cfg_p;
      pm_nxt        = cfg_pm;
      deadline_nxt  = {{(TIME_W-MS_W){1'b0}}, cfg_pm};
      pulse_end_nxt = '0;
    end else if (fire) begin
      unique case (item.mode)
        MODE_SERVICE: begin
          if (armed_r && reached) begin
            deadline_nxt  = dl_sum[TIME_W-1:0];
            pulse_end_nxt = pl_sum[TIME_W-1:0];
          end
        end
        MODE_TOGGLE: begin
          armed_nxt     = !armed_r;
          pulse_end_nxt = item.now_ms;
          if (!armed_r) begin
            deadline_nxt = dl_sum[TIME_W-1:0];
          end
        end
        MODE_STOP: begin
          armed_nxt     = 1'b0;
          pulse_end_nxt = item.now_ms;
        end
        MODE_ADJUST: begin
          period_nxt   = adj_p;
          pm_nxt       = adj_pm;
          deadline_nxt = adj_dl[TIME_W-1:0];
        end
        default: begin
          armed_nxt = armed_r;
        end
      endcase
    end
  end

  always_comb begin
    svc_nxt.active     = armed_r;
    svc_nxt.per_secs   = period_r;
    svc_nxt.rem_direct = REM_W'(period_r);
    svc_nxt.use_div    = 1'b0;
    svc_nxt.diff_ms    = deadline_r - item.now_ms;
    svc_nxt.pulse_act  = 1'b0;
    if (armed_r) begin
      if (reached) begin
        // fresh deadline: a full period ahead unless it wrapped
        svc_nxt.rem_direct = dl_sum[TIME_W] ? '0 : REM_W'(period_r);
        svc_nxt.pulse_act  = item.allow_outputs && !pl_sum[TIME_W];
      end else begin
        svc_nxt.use_div   = 1'b1;
        svc_nxt.pulse_act = item.allow_outputs && (item.now_ms < pulse_end_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      period_r    <= RST_P;
      pm_r        <= RST_MS;
      deadline_r  <= '0;
      pulse_end_r <= '0;
      svc_v_r     <= 1'b0;
    end else begin
      armed_r     <= armed_nxt;
      period_r    <= period_nxt;
      pm_r        <= pm_nxt;
      deadline_r  <= deadline_nxt;
      pulse_end_r <= pulse_end_nxt;
      if (stage_ready) begin
        svc_v_r <= fire && (item.mode == MODE_SERVICE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ready) begin
      svc_r <= svc_nxt;
    end
  end

  assign svc_valid = svc_v_r;
  assign svc       = svc_r;

`include "periodic_reminder_pulse_timer_core_assert.svh"

  `PRPT_ASSERT_IMP(a_period_range, clk, rst_n, 1'b1, (period_r >= MIN_P && period_r <= MAX_P))
  `PRPT_ASSERT_IMP(a_period_ms_match, clk, rst_n, 1'b1, (pm_r == MS_W'({{(MS_W-PERIOD_W){1'b0}}, period_r} * MS_K)))
  `PRPT_ASSERT_NXT(a_cfg_disarms, clk, rst_n, cfg_valid, (!armed_r && pulse_end_r == '0))

endmodule

### rtl/core/prpt_remain.sv
// ----------------------------------------------------------------------------
// prpt_remain
// remaining-seconds rounding and saturation, result output register
// ----------------------------------------------------------------------------
module prpt_remain import prpt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    s_valid,
  input  svc_t    s,
  output logic    s_ready,
  output logic    out_valid,
  output result_t out_res,
  input  logic    out_ready
);

  localparam int X_W = RECIP_W;

  logic    out_v_r;
  result_t res_r, res_nxt;

  logic [X_W-1:0]       x;
  logic [2*X_W-1:0]     prod;
  logic                 sat;
  rem_t                 div_q;

  assign s_ready = !out_v_r || out_ready;

  // ceiling of milliseconds over 1000 through a reciprocal multiply
  assign sat   = s.diff_ms > TIME_W'(SAT_MS);
  assign x     = X_W'(s.diff_ms[MS_W-1:0]) + X_W'(ROUND_UP_MS);
  assign prod  = {{X_W{1'b0}}, x} * (2*X_W)'(RECIP);
  assign div_q = prod[RECIP_SHIFT +: REM_W];

  always_comb begin
    res_nxt.active    = s.active;
    res_nxt.per_secs  = s.per_secs;
    res_nxt.pulse_act = s.pulse_act;
    if (!s.use_div) begin
      res_nxt.rem_secs = s.rem_direct;
    end else if (sat) begin
      res_nxt.rem_secs = REM_W'(REMAIN_MAX);
    end else begin
      res_nxt.rem_secs = div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s_ready) begin
      out_v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = res_r;

`include "periodic_reminder_pulse_timer_core_assert.svh"

  `PRPT_ASSERT_IMP(a_idle_rem_is_period, clk, rst_n, (out_v_r && !res_r.active), (res_r.rem_secs == REM_W'(res_r.per_secs)))
  `PRPT_ASSERT_IMP(a_pulse_needs_active, clk, rst_n, (out_v_r && res_r.pulse_act), res_r.active)
  `PRPT_ASSERT_NXT(a_direct_passes, clk, rst_n, (s_valid && s_ready && !s.use_div), (res_r.rem_secs == $past(s.rem_direct)))

endmodule
